### hdl/stau_pkg.sv
// Shared types, codes and constants for the sec/usec time arithmetic unit.
// No dependencies; imported by every other module in hdl/ and sim/.
package stau_pkg;

  typedef enum logic [1:0] {
    TAG_NORMAL  = 2'd0,
    TAG_INHERIT = 2'd1,
    TAG_INF     = 2'd2
  } tag_t;

  // Raw tag code with no meaning of its own; decoded as infinity.
  localparam logic [1:0] TAG_RAW_SPARE = 2'd3;

  typedef enum logic [3:0] {
    K_SEC   = 4'd0,
    K_MSEC  = 4'd1,
    K_USEC  = 4'd2,
    K_PLUS  = 4'd3,
    K_MINUS = 4'd4,
    K_MIN   = 4'd5,
    K_EQ    = 4'd6,
    K_NE    = 4'd7,
    K_LT    = 4'd8,
    K_LE    = 4'd9,
    K_GT    = 4'd10,
    K_GE    = 4'd11
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_INHERIT = 2'd1,
    ERR_INFINF  = 2'd2,
    ERR_OVF     = 2'd3
  } err_t;

  localparam logic [19:0] USEC_DIV  = 20'd1000000;
  localparam logic [19:0] MSEC_DIV  = 20'd1000;
  localparam logic [19:0] MS_SCALE  = 20'd1000;
  localparam logic [20:0] USEC_WRAP = 21'd1000000;
  // floor(2^32 / divisor): estimate is low by at most one
  localparam logic [22:0] RECIP_MS  = 23'd4294967;
  localparam logic [22:0] RECIP_US  = 23'd4294;

  localparam logic signed [33:0] SEC_MAX_W = 34'sd2147483647;
  localparam logic signed [33:0] SEC_MIN_W = -34'sd2147483648;

  typedef struct packed {
    tag_t               tag;
    logic signed [31:0] sec;
    logic [19:0]        usec;
  } opnd_t;

  typedef struct packed {
    logic signed [31:0] sec;
    logic [20:0]        usec;
    logic               ovf;
  } arith_t;

  typedef struct packed {
    kind_t              kind;
    opnd_t              a;
    opnd_t              b;
    logic signed [31:0] count;
    logic               neg;
    logic               lt_ab;
    logic               eq_ab;
  } ctx_t;

  typedef struct packed {
    ctx_t               ctx;
    logic [31:0]        mag;
    logic [20:0]        usum;
    logic signed [20:0] udiff;
    logic signed [32:0] ssum;
    logic signed [32:0] sdiff;
  } s1_t;

  typedef struct packed {
    ctx_t        ctx;
    arith_t      pl;
    arith_t      mi;
    logic [31:0] mag;
    logic [54:0] prod;
  } s2_t;

  typedef struct packed {
    ctx_t        ctx;
    arith_t      pl;
    arith_t      mi;
    logic [22:0] quo;
    logic [20:0] rem;
  } s3_t;

  typedef struct packed {
    tag_t               tag;
    logic signed [31:0] sec;
    logic signed [20:0] usec;
    logic               truth;
    err_t               err;
  } res_t;

  function automatic logic [19:0] conv_div(input kind_t k);
    return (k == K_MSEC) ? MSEC_DIV : USEC_DIV;
  endfunction

  function automatic logic [22:0] conv_recip(input kind_t k);
    return (k == K_MSEC) ? RECIP_MS : RECIP_US;
  endfunction

endpackage

### hdl/stau_pre.sv
// First pipeline stage logic: tag decode, count magnitude, raw sums/differences, compares.
// Depends on stau_pkg.
module stau_pre
  import stau_pkg::*;
(
  input  logic [3:0]  kind,
  input  logic [1:0]  a_tag,
  input  logic [31:0] a_sec,
  input  logic [19:0] a_usec,
  input  logic [1:0]  b_tag,
  input  logic [31:0] b_sec,
  input  logic [19:0] b_usec,
  input  logic [31:0] count,
  output s1_t         s1
);

  logic sec_lt;
  logic sec_eq;

  always_comb begin
    s1 = '0;
    s1.ctx.kind   = kind_t'(kind);
    s1.ctx.a.tag  = (a_tag == TAG_RAW_SPARE) ? TAG_INF : tag_t'(a_tag);
    s1.ctx.a.sec  = a_sec;
    s1.ctx.a.usec = a_usec;
    s1.ctx.b.tag  = (b_tag == TAG_RAW_SPARE) ? TAG_INF : tag_t'(b_tag);
    s1.ctx.b.sec  = b_sec;
    s1.ctx.b.usec = b_usec;
    s1.ctx.count  = count;
    s1.ctx.neg    = count[31];
    // |count| as unsigned; the most negative count wraps to 2^31 correctly
    s1.mag        = count[31] ? 32'(-count) : count;

    sec_lt = $signed(a_sec) < $signed(b_sec);
    sec_eq = a_sec == b_sec;
    s1.ctx.lt_ab = sec_lt || (sec_eq && (a_usec < b_usec));
    s1.ctx.eq_ab = sec_eq && (a_usec == b_usec);

    s1.usum  = {1'b0, a_usec} + {1'b0, b_usec};
    s1.udiff = $signed({1'b0, a_usec}) - $signed({1'b0, b_usec});
    s1.ssum  = $signed({a_sec[31], a_sec}) + $signed({b_sec[31], b_sec});
    s1.sdiff = $signed({a_sec[31], a_sec}) - $signed({b_sec[31], b_sec});
  end

endmodule

### hdl/stau_sel.sv
// Last pipeline stage logic: quotient correction, case rules per kind, result select.
// Depends on stau_pkg.
module stau_sel
  import stau_pkg::*;
(
  input  s3_t  s3,
  output res_t res
);

  logic [19:0] div;
  logic        fix;
  logic [22:0] quo;
  logic [19:0] rem;
  logic [19:0] umag;
  logic [31:0] smag;
  logic [20:0] uext;
  logic        a_inf;
  logic        b_inf;
  logic        a_inh;
  logic        b_inh;
  logic        eqv;

  always_comb begin
    div  = conv_div(s3.ctx.kind);
    fix  = s3.rem >= {1'b0, div};
    quo  = fix ? s3.quo + 23'd1 : s3.quo;
    rem  = fix ? 20'(s3.rem - {1'b0, div}) : s3.rem[19:0];
    umag = (s3.ctx.kind == K_MSEC) ? 20'(rem[9:0]) * MS_SCALE : rem;
    smag = {9'd0, quo};
    uext = {1'b0, umag};

    a_inf = s3.ctx.a.tag == TAG_INF;
    b_inf = s3.ctx.b.tag == TAG_INF;
    a_inh = s3.ctx.a.tag == TAG_INHERIT;
    b_inh = s3.ctx.b.tag == TAG_INHERIT;
    eqv   = (a_inf || b_inf) ? (s3.ctx.a.tag == s3.ctx.b.tag) : s3.ctx.eq_ab;

    res = '0;
    case (s3.ctx.kind)
      K_SEC: begin
        res.sec = s3.ctx.count;
      end
      K_MSEC, K_USEC: begin
        res.sec  = s3.ctx.neg ? 32'(-smag) : smag;
        res.usec = s3.ctx.neg ? 21'(-uext) : uext;
      end
      K_PLUS: begin
        if (a_inh) begin
          res.tag  = s3.ctx.b.tag;
          res.sec  = s3.ctx.b.sec;
          res.usec = {1'b0, s3.ctx.b.usec};
        end else if (a_inf || b_inf) begin
          res.tag = TAG_INF;
        end else if (b_inh) begin
          res.sec  = s3.ctx.a.sec;
          res.usec = {1'b0, s3.ctx.a.usec};
        end else begin
          res.sec  = s3.pl.sec;
          res.usec = s3.pl.usec;
          res.err  = s3.pl.ovf ? ERR_OVF : ERR_NONE;
        end
      end
      K_MINUS: begin
        if (a_inh || b_inh) begin
          res.err = ERR_INHERIT;
        end else if (a_inf && b_inf) begin
          res.err = ERR_INFINF;
        end else if (a_inf) begin
          res.tag = TAG_INF;
        end else if (!b_inf) begin
          res.sec  = s3.mi.sec;
          res.usec = s3.mi.usec;
          res.err  = s3.mi.ovf ? ERR_OVF : ERR_NONE;
        end
      end
      K_MIN: begin
        // b wins a tie; a non-normal a yields b as given
        if (s3.ctx.a.tag != TAG_NORMAL ||
            (s3.ctx.b.tag == TAG_NORMAL && !s3.ctx.lt_ab)) begin
          res.tag  = s3.ctx.b.tag;
          res.sec  = s3.ctx.b.sec;
          res.usec = {1'b0, s3.ctx.b.usec};
        end else begin
          res.tag  = s3.ctx.a.tag;
          res.sec  = s3.ctx.a.sec;
          res.usec = {1'b0, s3.ctx.a.usec};
        end
      end
      K_EQ, K_NE, K_LT, K_LE, K_GT, K_GE: begin
        if (a_inh || b_inh) begin
          res.err = ERR_INHERIT;
        end else begin
          case (s3.ctx.kind)
            K_EQ:    res.truth = eqv;
            K_NE:    res.truth = !eqv;
            K_LT:    res.truth = !a_inf && (b_inf || s3.ctx.lt_ab);
            K_LE:    res.truth = !a_inf && (b_inf || s3.ctx.lt_ab || s3.ctx.eq_ab);
            K_GT:    res.truth = !b_inf && (a_inf || !(s3.ctx.lt_ab || s3.ctx.eq_ab));
            K_GE:    res.truth = !b_inf && (a_inf || !s3.ctx.lt_ab);
            default: res.truth = 1'b0;
          endcase
        end
      end
      default: begin
        res = '0;
      end
    endcase

    if (res.tag != TAG_NORMAL) begin
      res.sec  = '0;
      res.usec = '0;
    end
  end

endmodule

### hdl/sec_usec_time_alu.sv
// Top level of the seconds-plus-microseconds time arithmetic unit.
// Depends on stau_pkg, stau_pre and stau_sel.
//
// Usage:
//  - Input channel in_valid/in_ready carries one operation per transaction:
//    in_kind, tagged operands a and b (seconds + microseconds), and in_count
//    for the sec/ms/us conversions.
//  - Result channel out_valid/out_ready returns exactly one result per
//    operation, in order: tag, seconds, microseconds, compare truth, error.
//  - Four register stages: operand decode and raw sums, then reciprocal
//    multiply with carry/borrow and saturation, then quotient-times-divisor
//    remainder, then correction and result select into the output register.
//  - Throughput is one transaction per cycle while the receiver keeps
//    out_ready high. The deepest steps are the 32x23 reciprocal
//    multiply (stage 2) and the 23x20 back-multiply (stage 3).
//  - Division of the count by 1000 or 1000000 uses floor(2^32/D) and one
//    compare-subtract fix-up; no divider is built.
//  - Each stage holds its own valid bit and loads whenever it is empty or
//    its successor loads, so bubbles collapse and an item keeps entering
//    while a finished result waits at the output.
//  - When the receiver stalls, the output register holds its transaction;
//    the stages fill behind it and in_ready drops once all four are full.
//  - Synchronous active-low reset empties all stages; no payload is reset.
//    There is no configuration and no state carried between operations.
module sec_usec_time_alu
  import stau_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_kind,
  input  logic [1:0]  in_a_tag,
  input  logic [31:0] in_a_sec,
  input  logic [19:0] in_a_usec,
  input  logic [1:0]  in_b_tag,
  input  logic [31:0] in_b_sec,
  input  logic [19:0] in_b_usec,
  input  logic [31:0] in_count,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_res_tag,
  output logic [31:0] out_res_sec,
  output logic [20:0] out_res_usec,
  output logic        out_truth,
  output logic [1:0]  out_error
);

  // stage valid bits and payload registers
  logic s1_v_r;
  logic s2_v_r;
  logic s3_v_r;
  logic out_v_r;
  s1_t  s1_r;
  s2_t  s2_r;
  s3_t  s3_r;
  res_t out_r;

  // stage load enables, back to front
  logic ld1;
  logic ld2;
  logic ld3;
  logic ldo;

  s1_t  s1_nxt;
  s2_t  s2_nxt;
  s3_t  s3_nxt;
  res_t out_nxt;

  assign ldo = !out_v_r || out_ready;
  assign ld3 = !s3_v_r || ldo;
  assign ld2 = !s2_v_r || ld3;
  assign ld1 = !s1_v_r || ld2;

  assign in_ready = ld1;

  // ---- stage 1: decode, magnitude, raw sums/differences, compares
  stau_pre u_pre (
    .kind   (in_kind),
    .a_tag  (in_a_tag),
    .a_sec  (in_a_sec),
    .a_usec (in_a_usec),
    .b_tag  (in_b_tag),
    .b_sec  (in_b_sec),
    .b_usec (in_b_usec),
    .count  (in_count),
    .s1     (s1_nxt)
  );

  // ---- stage 2: carry/borrow fix-up, saturation, reciprocal multiply
  logic               carry;
  logic               borrow;
  logic signed [33:0] psum;
  logic signed [33:0] mdif;

  always_comb begin
    s2_nxt     = '0;
    s2_nxt.ctx = s1_r.ctx;
    s2_nxt.mag = s1_r.mag;
    s2_nxt.prod = s1_r.mag * conv_recip(s1_r.ctx.kind);

    // plus: single carry step when the usec sum reaches one second
    carry = s1_r.usum >= USEC_WRAP;
    s2_nxt.pl.usec = carry ? 21'(s1_r.usum - USEC_WRAP) : s1_r.usum;
    psum = $signed({s1_r.ssum[32], s1_r.ssum}) + $signed({33'd0, carry});
    if (psum > SEC_MAX_W) begin
      s2_nxt.pl.sec = SEC_MAX_W[31:0];
      s2_nxt.pl.ovf = 1'b1;
    end else if (psum < SEC_MIN_W) begin
      s2_nxt.pl.sec = SEC_MIN_W[31:0];
      s2_nxt.pl.ovf = 1'b1;
    end else begin
      s2_nxt.pl.sec = psum[31:0];
      s2_nxt.pl.ovf = 1'b0;
    end

    // minus: borrow, clamp negative seconds to zero, then saturate high
    borrow = s1_r.udiff[20];
    s2_nxt.mi.usec = borrow ? 21'(s1_r.udiff + USEC_WRAP) : s1_r.udiff;
    mdif = $signed({s1_r.sdiff[32], s1_r.sdiff}) - $signed({33'd0, borrow});
    if (mdif[33]) begin
      s2_nxt.mi.sec = '0;
      s2_nxt.mi.ovf = 1'b0;
    end else if (mdif > SEC_MAX_W) begin
      s2_nxt.mi.sec = SEC_MAX_W[31:0];
      s2_nxt.mi.ovf = 1'b1;
    end else begin
      s2_nxt.mi.sec = mdif[31:0];
      s2_nxt.mi.ovf = 1'b0;
    end
  end

  // ---- stage 3: quotient estimate times divisor, remainder (< 2*divisor)
  logic [42:0] qd;

  always_comb begin
    s3_nxt     = '0;
    s3_nxt.ctx = s2_r.ctx;
    s3_nxt.pl  = s2_r.pl;
    s3_nxt.mi  = s2_r.mi;
    s3_nxt.quo = s2_r.prod[54:32];
    qd         = s3_nxt.quo * conv_div(s2_r.ctx.kind);
    s3_nxt.rem = 21'(s2_r.mag - qd[31:0]);
  end

  // ---- stage 4: correction and result select
  stau_sel u_sel (
    .s3  (s3_r),
    .res (out_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (ld1) begin
        s1_v_r <= in_valid;
      end
      if (ld2) begin
        s2_v_r <= s1_v_r;
      end
      if (ld3) begin
        s3_v_r <= s2_v_r;
      end
      if (ldo) begin
        out_v_r <= s3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_r <= s1_nxt;
    end
    if (ld2) begin
      s2_r <= s2_nxt;
    end
    if (ld3) begin
      s3_r <= s3_nxt;
    end
    if (ldo) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid    = out_v_r;
  assign out_res_tag  = out_r.tag;
  assign out_res_sec  = out_r.sec;
  assign out_res_usec = out_r.usec;
  assign out_truth    = out_r.truth;
  assign out_error    = out_r.err;

  // ---- assertions
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_v_r)
    else $error("accepted transaction did not enter stage 1");

  a_ovf_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error == ERR_OVF) |-> (out_res_tag == TAG_NORMAL))
    else $error("seconds overflow with non-normal tag");

  a_nonnormal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_res_tag != TAG_NORMAL) |-> (out_res_sec == '0) && (out_res_usec == '0))
    else $error("non-normal result carries time fields");

  a_truth_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_truth |-> (out_error == ERR_NONE) && (out_res_tag == TAG_NORMAL))
    else $error("compare truth set with error or tag");

endmodule

### sim/stau_result_check.sv
// Result checker for sec_usec_time_alu: predicts each operation's result on
// input acceptance and compares it with the next result that leaves the unit.
// Depends on stau_pkg for tag, kind and error codes.
module stau_result_check
  import stau_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  in_kind,
  input  logic [1:0]  in_a_tag,
  input  logic [31:0] in_a_sec,
  input  logic [19:0] in_a_usec,
  input  logic [1:0]  in_b_tag,
  input  logic [31:0] in_b_sec,
  input  logic [19:0] in_b_usec,
  input  logic [31:0] in_count,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_res_tag,
  input  logic [31:0] out_res_sec,
  input  logic [20:0] out_res_usec,
  input  logic        out_truth,
  input  logic [1:0]  out_error,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint USEC_PER_SEC = 1000000;
  localparam longint MSEC_PER_SEC = 1000;
  localparam longint SEC_TOP      = 64'sd2147483647;
  localparam longint SEC_BOTTOM   = -64'sd2147483648;

  typedef struct packed {
    logic [1:0]  tag;
    logic [31:0] sec;
    logic [20:0] usec;
    logic        truth;
    logic [1:0]  err;
  } time_result_t;

  time_result_t awaited_results[$];
  int           fail_count = 0;

  // Spare tag code decodes as infinity.
  function automatic logic [1:0] decode_tag(input logic [1:0] raw);
    return (raw == TAG_RAW_SPARE) ? TAG_INF : raw;
  endfunction

  function automatic bit time_less(input longint xs, input longint xu,
                                   input longint ys, input longint yu,
                                   input bit or_equal);
    if (xs != ys) return xs < ys;
    return or_equal ? (xu <= yu) : (xu < yu);
  endfunction

  function automatic time_result_t compute_time_op(
    input logic [3:0] kind,
    input logic [1:0] a_tag_raw, input logic [31:0] a_sec_raw,
    input logic [19:0] a_usec_raw,
    input logic [1:0] b_tag_raw, input logic [31:0] b_sec_raw,
    input logic [19:0] b_usec_raw,
    input logic [31:0] count_raw);
    logic [1:0]   at, bt, rt, xt, yt, err;
    longint       as, au, bs, bu, rs, ru, cnt, xs, xu, ys, yu;
    logic         truth;
    bit           is_cmp, eq, swap, or_eq;
    time_result_t r;
    at  = decode_tag(a_tag_raw);
    bt  = decode_tag(b_tag_raw);
    as  = longint'($signed(a_sec_raw));
    au  = longint'(a_usec_raw);
    bs  = longint'($signed(b_sec_raw));
    bu  = longint'(b_usec_raw);
    cnt = longint'($signed(count_raw));
    rt = TAG_NORMAL;
    rs = 0;
    ru = 0;
    truth = 1'b0;
    err = ERR_NONE;
    is_cmp = 1'b0;
    case (kind)
      K_SEC: rs = cnt;
      K_MSEC: begin
        rs = cnt / MSEC_PER_SEC;
        ru = 1000 * (cnt % MSEC_PER_SEC);
      end
      K_USEC: begin
        rs = cnt / USEC_PER_SEC;
        ru = cnt % USEC_PER_SEC;
      end
      K_PLUS: begin
        if (at == TAG_INHERIT) begin
          rt = bt; rs = bs; ru = bu;
        end else if (at == TAG_INF) begin
          rt = TAG_INF;
        end else if (bt == TAG_INHERIT) begin
          rt = at; rs = as; ru = au;
        end else if (bt == TAG_INF) begin
          rt = TAG_INF;
        end else begin
          ru = au + bu;
          rs = as + bs;
          if (ru >= USEC_PER_SEC) begin
            ru -= USEC_PER_SEC;
            rs += 1;
          end
        end
      end
      K_MINUS: begin
        if (at == TAG_INHERIT || bt == TAG_INHERIT) err = ERR_INHERIT;
        else if (at == TAG_INF && bt == TAG_INF) err = ERR_INFINF;
        else if (at == TAG_INF) rt = TAG_INF;
        else if (bt == TAG_INF) rs = 0;  // normal minus infinity: zero time
        else begin
          rs = as;
          ru = au - bu;
          if (ru < 0) begin
            ru += USEC_PER_SEC;
            rs -= 1;
          end
          rs = rs - bs;
          if (rs < 0) rs = 0;
        end
      end
      K_MIN: begin
        if (at != TAG_NORMAL) begin
          rt = bt; rs = bs; ru = bu;
        end else if (bt != TAG_NORMAL || time_less(as, au, bs, bu, 1'b0)) begin
          rt = at; rs = as; ru = au;
        end else begin
          rt = bt; rs = bs; ru = bu;
        end
      end
      K_EQ, K_NE, K_LT, K_LE, K_GT, K_GE: begin
        is_cmp = 1'b1;
        if (at == TAG_INHERIT || bt == TAG_INHERIT) begin
          err = ERR_INHERIT;
        end else if (kind == K_EQ || kind == K_NE) begin
          if (at == TAG_INF || bt == TAG_INF) eq = (at == bt);
          else eq = (as == bs && au == bu);
          truth = (kind == K_EQ) ? eq : !eq;
        end else begin
          // gt/ge are lt/le with the operands swapped
          swap  = (kind == K_GT || kind == K_GE);
          or_eq = (kind == K_LE || kind == K_GE);
          xt = swap ? bt : at;  yt = swap ? at : bt;
          xs = swap ? bs : as;  ys = swap ? as : bs;
          xu = swap ? bu : au;  yu = swap ? au : bu;
          if (xt == TAG_INF) truth = 1'b0;
          else if (yt == TAG_INF) truth = 1'b1;
          else truth = time_less(xs, xu, ys, yu, or_eq);
        end
      end
      default: ;
    endcase
    if ((kind == K_PLUS || kind == K_MINUS) && err == ERR_NONE && rt == TAG_NORMAL) begin
      if (rs > SEC_TOP) begin
        rs = SEC_TOP; err = ERR_OVF;
      end else if (rs < SEC_BOTTOM) begin
        rs = SEC_BOTTOM; err = ERR_OVF;
      end
    end
    if (is_cmp || err == ERR_INHERIT || err == ERR_INFINF || kind > K_GE) begin
      rt = TAG_NORMAL; rs = 0; ru = 0;
    end
    if (rt != TAG_NORMAL) begin
      rs = 0; ru = 0;
    end
    r.tag   = rt;
    r.sec   = rs[31:0];
    r.usec  = ru[20:0];
    r.truth = truth;
    r.err   = err;
    return r;
  endfunction

  always @(posedge clk) begin
    time_result_t want, got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_res_tag, out_res_sec, out_res_usec, out_truth, out_error};
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with nothing awaited: tag %0d sec %0d usec %0d",
                     $realtime, got.tag, $signed(got.sec), $signed(got.usec));
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $write("%0t: mismatch exp/act tag %0d/%0d sec %0d/%0d",
                     $realtime, want.tag, got.tag, $signed(want.sec), $signed(got.sec));
              $display(" usec %0d/%0d truth %0d/%0d err %0d/%0d",
                       $signed(want.usec), $signed(got.usec), want.truth, got.truth,
                       want.err, got.err);
            end
          end
        end
      end
      if (in_valid && in_ready)
        awaited_results.push_back(compute_time_op(in_kind, in_a_tag, in_a_sec, in_a_usec,
                                                  in_b_tag, in_b_sec, in_b_usec, in_count));
    end
    mismatches  <= fail_count;
    outstanding <= awaited_results.size();
  end

endmodule

### sim/tb.sv
// Testbench top for sec_usec_time_alu: clock, reset, operation stimulus,
// receiver back-pressure, watchdog and verdict.
// Depends on stau_pkg, the unit's RTL and stau_result_check.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stau_pkg::*;

  // Kind codes past K_GE decode to an all-zero result.
  localparam logic [3:0] KIND_SPARE_LO = 4'd12;
  localparam logic [3:0] KIND_SPARE_HI = 4'd15;

  localparam int N_RANDOM       = 550;
  localparam int QUIET_FROM     = 330;  // no idling on either side in this window
  localparam int QUIET_TO       = 430;
  localparam int HOLD_AT        = 150;  // receiver holds off after this many inputs
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [3:0]  kind;
    logic [1:0]  a_tag;
    logic [31:0] a_sec;
    logic [19:0] a_usec;
    logic [1:0]  b_tag;
    logic [31:0] b_sec;
    logic [19:0] b_usec;
    logic [31:0] count;
  } time_op_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  in_kind;
  logic [1:0]  in_a_tag;
  logic [31:0] in_a_sec;
  logic [19:0] in_a_usec;
  logic [1:0]  in_b_tag;
  logic [31:0] in_b_sec;
  logic [19:0] in_b_usec;
  logic [31:0] in_count;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_res_tag;
  logic [31:0] out_res_sec;
  logic [20:0] out_res_usec;
  logic        out_truth;
  logic [1:0]  out_error;

  int mismatches;
  int outstanding;
  int n_accepted = 0;
  bit calm = 1'b0;  // sender's no-idle window, mirrored to the receiver

  sec_usec_time_alu u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_a_tag     (in_a_tag),
    .in_a_sec     (in_a_sec),
    .in_a_usec    (in_a_usec),
    .in_b_tag     (in_b_tag),
    .in_b_sec     (in_b_sec),
    .in_b_usec    (in_b_usec),
    .in_count     (in_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_res_tag  (out_res_tag),
    .out_res_sec  (out_res_sec),
    .out_res_usec (out_res_usec),
    .out_truth    (out_truth),
    .out_error    (out_error)
  );

  stau_result_check u_check (.*);

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) n_accepted <= 0;
    else if (in_valid && in_ready) n_accepted <= n_accepted + 1;
  end

  function automatic time_op_t mk_op(
    input logic [3:0] kind,
    input logic [1:0] at, input logic [31:0] as, input logic [19:0] au,
    input logic [1:0] bt, input logic [31:0] bs, input logic [19:0] bu,
    input logic [31:0] cnt);
    return '{kind, at, as, au, bt, bs, bu, cnt};
  endfunction

  // Mostly normal tags; inherit, infinity and the spare code mixed in.
  function automatic logic [1:0] rand_tag();
    int r;
    r = $urandom_range(99);
    if (r < 70) return TAG_NORMAL;
    if (r < 82) return TAG_INHERIT;
    if (r < 95) return TAG_INF;
    return TAG_RAW_SPARE;
  endfunction

  function automatic logic [31:0] rand_sec();
    case ($urandom_range(7))
      0:       return $urandom;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'($urandom_range(2000)) - 32'd1000;
      4:       return $urandom_range(50);
      default: return $urandom_range(1000000000);
    endcase
  endfunction

  // Normalized usec most of the time; the odd unnormalized value above 999999.
  function automatic logic [19:0] rand_usec();
    int r;
    r = $urandom_range(99);
    if (r < 6)  return 20'($urandom);
    if (r < 12) return 20'd999999;
    if (r < 18) return 20'd0;
    return 20'($urandom_range(999999));
  endfunction

  function automatic logic [31:0] rand_count();
    logic [31:0] c;
    case ($urandom_range(5))
      0:       c = $urandom;
      1:       c = 32'($urandom_range(10000)) - 32'd5000;
      2:       c = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: c = $urandom_range(3000000);
    endcase
    if ($urandom_range(1)) c = -c;
    return c;
  endfunction

  function automatic time_op_t random_op();
    time_op_t op;
    op.kind   = ($urandom_range(99) < 3) ? 4'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI))
                                         : 4'($urandom_range(K_GE));
    op.a_tag  = rand_tag();
    op.a_sec  = rand_sec();
    op.a_usec = rand_usec();
    op.b_tag  = rand_tag();
    op.b_sec  = rand_sec();
    op.b_usec = rand_usec();
    op.count  = rand_count();
    // min and compares need ties and near-ties to be interesting
    if (op.kind >= K_MIN && op.kind <= K_GE) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          op.b_tag  = op.a_tag;
          op.b_sec  = op.a_sec;
          op.b_usec = op.a_usec;
        end
        3, 4: op.b_sec = op.a_sec;
        default: ;
      endcase
    end
    return op;
  endfunction

  // Present one transaction and hold it until the unit takes it.
  task automatic offer(input time_op_t op);
    in_valid  <= 1'b1;
    in_kind   <= op.kind;
    in_a_tag  <= op.a_tag;
    in_a_sec  <= op.a_sec;
    in_a_usec <= op.a_usec;
    in_b_tag  <= op.b_tag;
    in_b_sec  <= op.b_sec;
    in_b_usec <= op.b_usec;
    in_count  <= op.count;
    do @(posedge clk); while (!in_ready);
  endtask

  // Receiver: random stalls, one long hold-off once the pipe is busy so the
  // unit fills up and drops in_ready, and no stalls during the calm window.
  initial begin : receiver
    int  stall_left;
    bit  held;
    stall_left = 0;
    held       = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && n_accepted >= HOLD_AT) begin
        held       = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 12);
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    time_op_t directed_ops[$];
    int       n_total;
    bit       quiet;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_kind   = K_SEC;
    in_a_tag  = TAG_NORMAL;
    in_a_sec  = '0;
    in_a_usec = '0;
    in_b_tag  = TAG_NORMAL;
    in_b_sec  = '0;
    in_b_usec = '0;
    in_count  = '0;

    // Conversions: count extremes and negative counts (negative usec)
    directed_ops.push_back(mk_op(K_SEC, TAG_NORMAL, 0, 0, TAG_NORMAL, 0, 0, 32'h7FFF_FFFF));
    directed_ops.push_back(mk_op(K_SEC, TAG_NORMAL, 0, 0, TAG_NORMAL, 0, 0, 32'h8000_0000));
    directed_ops.push_back(mk_op(K_MSEC, TAG_NORMAL, 0, 0, TAG_NORMAL, 0, 0, -1999));
    directed_ops.push_back(mk_op(K_MSEC, TAG_NORMAL, 0, 0, TAG_NORMAL, 0, 0, 32'h7FFF_FFFF));
    directed_ops.push_back(mk_op(K_USEC, TAG_NORMAL, 0, 0, TAG_NORMAL, 0, 0, 32'h8000_0000));
    directed_ops.push_back(mk_op(K_USEC, TAG_NORMAL, 0, 0, TAG_NORMAL, 0, 0, 1999999));
    // Plus: carry, overflow both ways, inherit and infinity rules
    directed_ops.push_back(mk_op(K_PLUS, TAG_NORMAL, 5, 999999, TAG_NORMAL, 7, 1, 0));
    directed_ops.push_back(mk_op(K_PLUS, TAG_NORMAL, 32'h7FFF_FFFF, 999999,
                                 TAG_NORMAL, 32'h7FFF_FFFF, 999999, 0));
    directed_ops.push_back(mk_op(K_PLUS, TAG_NORMAL, 32'h8000_0000, 0,
                                 TAG_NORMAL, 32'h8000_0000, 0, 0));
    directed_ops.push_back(mk_op(K_PLUS, TAG_INHERIT, 1, 2, TAG_NORMAL, 3, 4, 0));
    directed_ops.push_back(mk_op(K_PLUS, TAG_INF, 1, 2, TAG_INHERIT, 3, 4, 0));
    directed_ops.push_back(mk_op(K_PLUS, TAG_NORMAL, 1, 2, TAG_INHERIT, 3, 4, 0));
    directed_ops.push_back(mk_op(K_PLUS, TAG_NORMAL, 1, 2, TAG_RAW_SPARE, 3, 4, 0));
    // Minus: borrow with clamp at zero, error cases, infinity rules, overflow
    directed_ops.push_back(mk_op(K_MINUS, TAG_NORMAL, 1, 0, TAG_NORMAL, 2, 500000, 0));
    directed_ops.push_back(mk_op(K_MINUS, TAG_NORMAL, 9, 9, TAG_INHERIT, 1, 1, 0));
    directed_ops.push_back(mk_op(K_MINUS, TAG_INF, 9, 9, TAG_INF, 1, 1, 0));
    directed_ops.push_back(mk_op(K_MINUS, TAG_INF, 9, 9, TAG_NORMAL, 1, 1, 0));
    directed_ops.push_back(mk_op(K_MINUS, TAG_NORMAL, 9, 9, TAG_INF, 1, 1, 0));
    directed_ops.push_back(mk_op(K_MINUS, TAG_NORMAL, 32'h7FFF_FFFF, 999999,
                                 TAG_NORMAL, 32'hFFFF_FFFF, 0, 0));
    // Min with a tie and with a non-normal first operand
    directed_ops.push_back(mk_op(K_MIN, TAG_NORMAL, 4, 10, TAG_NORMAL, 4, 10, 0));
    directed_ops.push_back(mk_op(K_MIN, TAG_INF, 4, 10, TAG_NORMAL, 8, 20, 0));
    // Compares: two infinities, le of infinities is false, inherit error
    directed_ops.push_back(mk_op(K_EQ, TAG_INF, 1, 1, TAG_RAW_SPARE, 2, 2, 0));
    directed_ops.push_back(mk_op(K_NE, TAG_NORMAL, 3, 5, TAG_NORMAL, 3, 6, 0));
    directed_ops.push_back(mk_op(K_LT, TAG_NORMAL, 3, 5, TAG_INF, 0, 0, 0));
    directed_ops.push_back(mk_op(K_LE, TAG_INF, 0, 0, TAG_INF, 0, 0, 0));
    directed_ops.push_back(mk_op(K_GT, TAG_NORMAL, 3, 5, TAG_INF, 0, 0, 0));
    directed_ops.push_back(mk_op(K_GE, TAG_INHERIT, 3, 5, TAG_NORMAL, 3, 5, 0));
    // Spare kind with unnormalized usec and the spare tag
    directed_ops.push_back(mk_op(KIND_SPARE_HI, TAG_RAW_SPARE, 32'hFFFF_FFFF, 20'hFFFFF,
                                 TAG_RAW_SPARE, 32'hFFFF_FFFF, 20'hFFFFF, 32'hFFFF_FFFF));

    n_total = directed_ops.size() + N_RANDOM;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < n_total; i++) begin
      quiet = (i >= QUIET_FROM && i < QUIET_TO);
      calm <= quiet;
      offer(i < directed_ops.size() ? directed_ops[i] : random_op());
      if (i == n_total - 1) begin
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(99) < 12) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end

    // Drain: wait out every awaited result, then keep watching for strays.
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
